// ----- sv/tcp_out_of_order_segment_store_macros.svh -----
// assertion macros shared by the segment store rtl
// expects clk and arst_n in the scope of each use
`ifndef TCP_OUT_OF_ORDER_SEGMENT_STORE_MACROS_SVH
`define TCP_OUT_OF_ORDER_SEGMENT_STORE_MACROS_SVH

// condition holds in the same cycle
`define TOOSS_ASSERT_IMPLY(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error("tooss assertion failed");

// condition holds in the following cycle
`define TOOSS_ASSERT_NEXT(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error("tooss assertion failed");

`endif

// ----- sv/tooss_pkg.sv -----
// types, sizes and status codes of the out-of-order segment store
// no dependencies
package tooss_pkg;

	localparam int SEG_MAX = 16;
	localparam int CNT_W = $clog2(SEG_MAX + 1);
	localparam int SEQ_W = 32;
	localparam int LEN_W = 16;
	localparam logic [SEQ_W:0] SEQ_TOP = {1'b1, {SEQ_W{1'b0}}};

	typedef enum logic [2:0] {
		ST_STORED  = 3'd0,
		ST_IGNORED = 3'd1,
		ST_DROPPED = 3'd2,
		ST_FULL    = 3'd3,
		ST_CLEARED = 3'd4
	} status_t;

	// one cell to its right neighbour
	typedef struct packed {
		logic             lt;
		logic [SEQ_W-1:0] start;
		logic [LEN_W-1:0] size;
	} link_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic             ins;
		logic [SEQ_W:0]   seg_end;
		logic [SEQ_W-1:0] new_start;
		logic [LEN_W-1:0] new_size;
	} bcast_t;

endpackage

// ----- sv/tooss_cell.sv -----
// one slot of the sorted segment chain: holds start and size,
// compares against the new end and shifts right on insert; uses tooss_pkg
module tooss_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      occ,
	input  tooss_pkg::bcast_t         bc,
	input  tooss_pkg::link_t          left,
	output tooss_pkg::link_t          right,
	output logic [tooss_pkg::SEQ_W:0] pe
);

	logic                          lt_q;
	logic [tooss_pkg::SEQ_W-1:0]   start_q;
	logic [tooss_pkg::LEN_W-1:0]   size_q;
	logic [tooss_pkg::SEQ_W:0]     pe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q <= 1'b0;
		end else begin
			lt_q <= occ && ({1'b0, start_q} < bc.seg_end);
		end
	end

	always_ff @(posedge clk) begin
		pe_q <= {1'b0, start_q} + {{(tooss_pkg::SEQ_W - tooss_pkg::LEN_W + 1){1'b0}}, size_q};
		if (bc.ins && !lt_q) begin
			if (left.lt) begin
				start_q <= bc.new_start;
				size_q  <= bc.new_size;
			end else begin
				start_q <= left.start;
				size_q  <= left.size;
			end
		end
	end

	assign right = '{lt: lt_q, start: start_q, size: size_q};
	assign pe    = pe_q;

endmodule

// ----- sv/tcp_out_of_order_segment_store.sv -----
// Out-of-order segment store for one flow: a chain of tooss_cell slots kept sorted by start,
// with the insert, trim and clear control. Uses tooss_pkg and the tooss assertion macros.
// Accepting a word clips the segment to the top of the sequence space; in S_CMP every cell
// compares its start with the new end; in S_DEC, once the output is free, the predecessor
// is picked, the front trim worked out, the result registered and the cells shifted. A new
// word is accepted once the result is registered; the result register is held until taken.
`include "tcp_out_of_order_segment_store_macros.svh"

module tcp_out_of_order_segment_store (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,  // seg_seq[31:0], seg_len[47:32], expected_seq[79:48]
	input  logic [0:0]  s_tuser,  // cmd[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,  // kept_seq[31:0], kept_len[47:32], front_trim[63:48],
	                              // slot_index[68:64], held_count[73:69], zero fill
	output logic [2:0]  m_tuser   // status[2:0]
);

	localparam int N  = tooss_pkg::SEG_MAX;
	localparam int CW = tooss_pkg::CNT_W;
	localparam int SW = tooss_pkg::SEQ_W;
	localparam int LW = tooss_pkg::LEN_W;

	typedef enum logic [1:0] {S_IDLE, S_CMP, S_DEC} state_t;

	state_t              state_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       count_nxt;
	tooss_pkg::status_t  status_q;
	tooss_pkg::status_t  status_nxt;
	logic [SW-1:0]       kseq_q;
	logic [LW-1:0]       klen_q;
	logic [LW-1:0]       ftrim_q;
	logic [CW-1:0]       slot_q;

	logic                cmd_q;
	logic                ahead_q;
	logic                zero_q;
	logic [SW-1:0]       seq_q;
	logic [LW-1:0]       len_q;
	logic [SW:0]         end_q;

	logic [SW-1:0]       in_seq;
	logic [LW-1:0]       in_len;
	logic [SW-1:0]       in_exp;
	logic [SW:0]         end_raw;
	logic                over;

	tooss_pkg::link_t    links [N+1];
	logic [SW:0]         pe_arr [N];
	logic [N-1:0]        lt_vec;
	logic [N-1:0]        occ_vec;
	logic [N-1:0]        pred_oh;
	logic [N:0]          bound_oh;
	logic [CW-1:0]       pos;
	logic [SW:0]         pe_sel;
	logic                front_pos;
	logic [SW:0]         front;
	logic                drop;
	logic [SW-1:0]       kseq_nxt;
	logic [LW-1:0]       klen_nxt;
	logic                dec_go;
	logic                store;
	tooss_pkg::bcast_t   bc;

	assign in_seq  = s_tdata[31:0];
	assign in_len  = s_tdata[47:32];
	assign in_exp  = s_tdata[79:48];
	assign end_raw = {1'b0, in_seq} + {{(SW - LW + 1){1'b0}}, in_len};
	assign over    = end_raw > tooss_pkg::SEQ_TOP;

	assign s_tready = (state_q == S_IDLE);

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q   <= s_tuser[0];
			ahead_q <= in_exp < in_seq;
			zero_q  <= (in_len == '0);
			seq_q   <= in_seq;
			len_q   <= over ? (~in_seq[LW-1:0] + 1'b1) : in_len;
			end_q   <= over ? tooss_pkg::SEQ_TOP : end_raw;
		end
	end

	// cell chain
	assign links[0] = '{lt: 1'b1, start: '0, size: '0};

	for (genvar i = 0; i < N; i++) begin : g_cell
		assign occ_vec[i] = CW'(i) < count_q;
		assign lt_vec[i]  = links[i+1].lt;
		tooss_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.occ    (occ_vec[i]),
			.bc     (bc),
			.left   (links[i]),
			.right  (links[i+1]),
			.pe     (pe_arr[i])
		);
	end

	// predecessor and insert position from the sorted compare prefix
	always_comb begin
		bound_oh[0] = ~lt_vec[0];
		for (int i = 1; i < N; i++) begin
			bound_oh[i] = lt_vec[i-1] & ~lt_vec[i];
		end
		bound_oh[N] = lt_vec[N-1];
		for (int i = 0; i < N - 1; i++) begin
			pred_oh[i] = lt_vec[i] & ~lt_vec[i+1];
		end
		pred_oh[N-1] = lt_vec[N-1];
		pos    = '0;
		pe_sel = '0;
		for (int i = 0; i <= N; i++) begin
			pos = pos | ({CW{bound_oh[i]}} & CW'(i));
		end
		for (int i = 0; i < N; i++) begin
			pe_sel = pe_sel | ({(SW+1){pred_oh[i]}} & pe_arr[i]);
		end
	end

	assign front_pos = (|lt_vec) && (pe_sel > {1'b0, seq_q});
	assign front     = front_pos ? (pe_sel - {1'b0, seq_q}) : '0;
	assign drop      = front >= {{(SW - LW + 1){1'b0}}, len_q};
	assign kseq_nxt  = front_pos ? pe_sel[SW-1:0] : seq_q;
	assign klen_nxt  = len_q - front[LW-1:0];

	always_comb begin
		store      = 1'b0;
		count_nxt  = count_q;
		status_nxt = tooss_pkg::ST_STORED;
		priority if (cmd_q) begin
			status_nxt = tooss_pkg::ST_CLEARED;
			count_nxt  = '0;
		end else if (!ahead_q) begin
			status_nxt = tooss_pkg::ST_IGNORED;
		end else if (zero_q || drop) begin
			status_nxt = tooss_pkg::ST_DROPPED;
		end else if (count_q == CW'(N)) begin
			status_nxt = tooss_pkg::ST_FULL;
		end else begin
			store     = 1'b1;
			count_nxt = count_q + 1'b1;
		end
	end

	assign dec_go = (state_q == S_DEC) && (!m_tvalid || m_tready);

	assign bc = '{ins: dec_go && store, seg_end: end_q,
		new_start: kseq_nxt, new_size: klen_nxt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			m_tvalid <= 1'b0;
			status_q <= tooss_pkg::ST_STORED;
			kseq_q   <= '0;
			klen_q   <= '0;
			ftrim_q  <= '0;
			slot_q   <= '0;
		end else begin
			if (dec_go) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_DEC;
				end
				S_DEC: begin
					if (dec_go) begin
						state_q  <= S_IDLE;
						count_q  <= count_nxt;
						status_q <= status_nxt;
						kseq_q   <= store ? kseq_nxt : '0;
						klen_q   <= store ? klen_nxt : '0;
						ftrim_q  <= store ? front[LW-1:0] : '0;
						slot_q   <= store ? pos : '0;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tuser = status_q;
	assign m_tdata = {6'b0, 5'(count_q), 5'(slot_q), ftrim_q, klen_q, kseq_q};

	`TOOSS_ASSERT_IMPLY(a_count_range, 1'b1, count_q <= CW'(N))
	`TOOSS_ASSERT_IMPLY(a_lt_prefix, state_q == S_DEC, ((lt_vec >> 1) & ~lt_vec) == '0)
	`TOOSS_ASSERT_NEXT(a_store_grows, bc.ins, count_q == CW'($past(count_q) + 1'b1))
	`TOOSS_ASSERT_IMPLY(a_clear_empty, m_tvalid && (m_tuser == tooss_pkg::ST_CLEARED),
		m_tdata[73:69] == 5'd0)

endmodule

// ----- tb/sv/tcp_out_of_order_segment_store_check.sv -----
`timescale 1ns / 100ps
// checker for the out-of-order segment store: predicts each result word from the input words
// and compares it with the output channel. Uses tooss_pkg.
module tcp_out_of_order_segment_store_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [79:0] s_tdata,  // seg_seq[31:0], seg_len[47:32], expected_seq[79:48]
	input  logic [0:0]  s_tuser,  // cmd[0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [79:0] m_tdata,  // kept_seq, kept_len, front_trim, slot_index, held_count
	input  logic [2:0]  m_tuser,  // status[2:0]
	output int          errors,
	output int          pending
);
	import tooss_pkg::*;

	typedef struct {
		status_t          status;
		logic [SEQ_W-1:0] kept_seq;
		logic [LEN_W-1:0] kept_len;
		logic [LEN_W-1:0] front_trim;
		logic [4:0]       slot;
		logic [4:0]       held;
	} seg_result_t;

	logic [SEQ_W-1:0] seg_lo [SEG_MAX];
	logic [LEN_W-1:0] seg_bytes [SEG_MAX];
	int               seg_fill;
	seg_result_t      result_q [$];

	function automatic seg_result_t store_segment(logic clr, logic [SEQ_W-1:0] seq,
			logic [LEN_W-1:0] len_in, logic [SEQ_W-1:0] exp_seq);
		seg_result_t r;
		logic [SEQ_W:0] len;
		logic [SEQ_W:0] room;
		logic [SEQ_W:0] seg_end;
		logic [SEQ_W:0] prev_end;
		logic [SEQ_W:0] front;
		int pos;
		r = '{ST_STORED, '0, '0, '0, '0, '0};
		if (clr) begin
			seg_fill = 0;
			r.status = ST_CLEARED;
			return r;
		end
		r.held = seg_fill[4:0];
		if (!(exp_seq < seq)) begin
			r.status = ST_IGNORED;
			return r;
		end
		if (len_in == 0) begin
			r.status = ST_DROPPED;
			return r;
		end
		// sequence space does not wrap: clip at the top
		len = len_in;
		room = SEQ_TOP - {1'b0, seq};
		if (len > room)
			len = room;
		seg_end = {1'b0, seq} + len;
		pos = 0;
		while (pos < seg_fill && {1'b0, seg_lo[pos]} < seg_end)
			pos++;
		front = '0;
		if (pos > 0) begin
			prev_end = {1'b0, seg_lo[pos-1]} + seg_bytes[pos-1];
			if (prev_end > {1'b0, seq})
				front = prev_end - seq;
		end
		if (front >= len) begin
			r.status = ST_DROPPED;
			return r;
		end
		if (seg_fill >= SEG_MAX) begin
			r.status = ST_FULL;
			return r;
		end
		for (int k = seg_fill; k > pos; k--) begin
			seg_lo[k] = seg_lo[k-1];
			seg_bytes[k] = seg_bytes[k-1];
		end
		seg_lo[pos] = seq + front[SEQ_W-1:0];
		seg_bytes[pos] = len[LEN_W-1:0] - front[LEN_W-1:0];
		seg_fill++;
		r.kept_seq = seg_lo[pos];
		r.kept_len = seg_bytes[pos];
		r.front_trim = front[LEN_W-1:0];
		r.slot = pos[4:0];
		r.held = seg_fill[4:0];
		return r;
	endfunction

	function automatic int field_bad(string fname, logic [31:0] want, logic [31:0] got);
		if (want === got)
			return 0;
		$display("%0t %s mismatch: expected %0h, actual %0h", $time, fname, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		seg_result_t want;
		int bad;
		if (!arst_n) begin
			seg_fill = 0;
			result_q.delete();
			errors <= 0;
			pending <= 0;
		end else begin
			bad = 0;
			if (s_tvalid && s_tready)
				result_q.push_back(store_segment(s_tuser[0], s_tdata[31:0], s_tdata[47:32],
					s_tdata[79:48]));
			if (m_tvalid && m_tready) begin
				if (result_q.size() == 0) begin
					$display("%0t unexpected result word: status %0d", $time, m_tuser);
					bad = 1;
				end else begin
					want = result_q.pop_front();
					bad += field_bad("status", 32'(want.status), 32'(m_tuser));
					bad += field_bad("kept_seq", want.kept_seq, m_tdata[31:0]);
					bad += field_bad("kept_len", 32'(want.kept_len), 32'(m_tdata[47:32]));
					bad += field_bad("front_trim", 32'(want.front_trim), 32'(m_tdata[63:48]));
					bad += field_bad("slot_index", 32'(want.slot), 32'(m_tdata[68:64]));
					bad += field_bad("held_count", 32'(want.held), 32'(m_tdata[73:69]));
				end
			end
			errors <= errors + bad;
			pending <= result_q.size();
		end
	end

endmodule

// ----- tb/sv/tcp_out_of_order_segment_store_tb.sv -----
`timescale 1ns / 100ps
// top of the segment store testbench: clock, reset, segment and clear words, output stalls
// and the verdict. Needs tcp_out_of_order_segment_store and its checker.
module tcp_out_of_order_segment_store_tb;
	import tooss_pkg::*;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;
	localparam int CYCLE_LIMIT = 600000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;
	logic [2:0]  m_tuser;
	int          errors;
	int          pending;
	int          cycles = 0;
	int          rx_hold = 0;
	int          rx_free = 0;

	always #1 clk = ~clk;

	tcp_out_of_order_segment_store DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	tcp_out_of_order_segment_store_check CHK (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.errors(errors), .pending(pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// output stalls, with occasional stretches of none
	always @(posedge clk) begin
		if (rx_free > 0) begin
			rx_free <= rx_free - 1;
			m_tready <= 1'b1;
		end else if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			case ($urandom_range(0, 99))
				0: rx_free <= $urandom_range(40, 200);
				1, 2, 3: rx_hold <= $urandom_range(8, 40);
				4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 16, 17, 18, 19: begin
					rx_hold <= $urandom_range(1, 3);
				end
				default: ;
			endcase
		end
	end

	function automatic int idle_gap(bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(4, 25);
	endfunction

	// called at a rising edge, returns at the edge where the word was taken
	task automatic push_word(input logic cmd, input logic [31:0] seq, input logic [15:0] len,
			input logic [31:0] exp_seq, input int gap);
		logic took;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {exp_seq, len, seq};
		do begin
			@(negedge clk);
			took = s_tready;
			@(posedge clk);
		end while (!took);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	initial begin
		logic [31:0] base;
		logic [31:0] seq;
		logic [31:0] exp_seq;
		logic [31:0] last_seq;
		logic [15:0] len;
		logic [15:0] last_len;
		int win;
		int r;
		bit calm;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: boundaries, trims, cover, zero length, top of space, full table
		push_word(CMD_INSERT, 32'd0, 16'd10, 32'd0, 0);
		push_word(CMD_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1);
		push_word(CMD_INSERT, 32'd100, 16'd10, 32'd0, 0);
		push_word(CMD_INSERT, 32'd105, 16'd10, 32'd0, 2);
		push_word(CMD_INSERT, 32'd100, 16'd10, 32'd0, 0);
		push_word(CMD_INSERT, 32'd50, 16'd20, 32'd0, 0);
		push_word(CMD_INSERT, 32'd90, 16'd0, 32'd0, 0);
		push_word(CMD_INSERT, 32'hFFFF_FFF0, 16'hFFFF, 32'hFFFF_FFEF, 3);
		push_word(CMD_INSERT, 32'hFFFF_FFFF, 16'd1, 32'd0, 0);
		for (int i = 0; i < 12; i++)
			push_word(CMD_INSERT, 32'd1000 + 32'(i) * 10, 16'd5, 32'd999, 0);
		push_word(CMD_INSERT, 32'd2000, 16'd1, 32'd0, 0);
		push_word(CMD_INSERT, 32'd1000, 16'd5, 32'd0, 0);
		push_word(CMD_CLEAR, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 0);
		drain();

		last_seq = 32'd0;
		last_len = 16'd1;
		for (int blk = 0; blk < 15; blk++) begin
			case ($urandom_range(0, 3))
				0: base = 32'hFFFF_FFFF - $urandom_range(0, 300000);
				1: base = $urandom_range(0, 5000);
				default: base = $urandom;
			endcase
			win = ($urandom_range(0, 3) == 0) ? $urandom_range(20000, 200000)
				: $urandom_range(32, 3000);
			calm = ($urandom_range(0, 4) == 0);
			if (blk % 4 == 2)
				drain();
			for (int i = 0; i < 100; i++) begin
				r = $urandom_range(0, 99);
				if (r < 4) begin
					push_word(CMD_CLEAR, $urandom, 16'($urandom), $urandom, idle_gap(calm));
					continue;
				end
				if (r < 12) begin
					push_word(CMD_INSERT, $urandom, 16'($urandom), $urandom, idle_gap(calm));
					continue;
				end
				if (r < 16)
					base = base + $urandom_range(1, win / 4 + 1);
				exp_seq = base;
				if (r < 31)
					seq = last_seq + $urandom_range(0, last_len);
				else
					seq = base + 1 + $urandom_range(0, win);
				if ($urandom_range(0, 99) < 85)
					len = 16'($urandom_range(1, win / 6 + 2));
				else
					len = 16'($urandom_range(1, 65535));
				push_word(CMD_INSERT, seq, len, exp_seq, idle_gap(calm));
				last_seq = seq;
				last_len = len;
			end
		end

		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
